>>> design/psrp_pkg.sv
// Package of types, constants and codes shared by the residency percentage block.
package psrp_pkg;

    // Fixed width of each input field on the stream port
    localparam int FIELD_W = 48;
    // Default counter width used for all wrapping arithmetic
    localparam int COUNTER_WIDTH_DEFAULT = 48;

    localparam int IN_DATA_W  = 4 * FIELD_W;
    localparam int OUT_DATA_W = 40;
    localparam int PCT_W      = 8;
    localparam int STATUS_W   = 2;

    localparam logic [6:0]       PCT_SCALE = 7'd100;
    localparam logic [PCT_W-1:0] PCT_MAX   = 8'd255;

    // Bits of counters_present
    localparam int BIT_DEEP    = 0;
    localparam int BIT_DEEPER  = 1;
    localparam int BIT_DEEPEST = 2;
    localparam int MASK_W      = 3;
    localparam logic [MASK_W-1:0] MASK_RESET = 3'd7;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_COUNTERS_PRESENT = 1'b0;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_VALID     = 2'd0,
        STATUS_NEED_MORE = 2'd1,
        STATUS_NO_TIME   = 2'd2
    } status_t;

    // Channel being divided
    typedef enum logic [1:0] {
        CH_DEEP     = 2'd0,
        CH_DEEPER   = 2'd1,
        CH_DEEPEST  = 2'd2,
        CH_COMBINED = 2'd3
    } chan_t;

    // Top level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SUM,
        ST_START,
        ST_WAIT,
        ST_FINISH
    } top_state_t;

    // Divider sequencer
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_SCALE,
        DV_ITER,
        DV_DONE
    } div_state_t;

    // Highest quotient bit step; step 8 only checks for saturation
    localparam logic [3:0] DIV_TOP_STEP = 4'd8;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quo;
    } div_rsp_t;

endpackage

>>> design/psrp_div.sv
// Shared scale-and-divide unit: min(255, (100*num + den/2) / den), one bit per cycle.
module psrp_div #(
    parameter int COUNTER_WIDTH = psrp_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [COUNTER_WIDTH+1:0]   num,
    input  logic [COUNTER_WIDTH-1:0]   den,
    output psrp_pkg::div_rsp_t         rsp
);
    import psrp_pkg::*;

    localparam int CW = COUNTER_WIDTH;
    localparam int NW = CW + 9;

    div_state_t      state_reg, state_next;
    logic [NW-1:0]   rem_reg;
    logic [PCT_W-1:0] q_reg;
    logic [3:0]      step_reg;

    logic [NW-1:0]   den_shift;
    logic [NW:0]     trial;
    logic            fits;
    logic [NW-1:0]   scaled;

    // One compare-subtract against the shifted divisor
    assign den_shift = {{(NW-CW){1'b0}}, den} << step_reg;
    assign trial     = {1'b0, rem_reg} - {1'b0, den_shift};
    assign fits      = ~trial[NW];
    assign scaled    = (NW'(num) * PCT_SCALE) + NW'(den >> 1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:  if (start) state_next = DV_SCALE;
            DV_SCALE: state_next = DV_ITER;
            DV_ITER: begin
                if ((step_reg == DIV_TOP_STEP && fits) || step_reg == 4'd0) begin
                    state_next = DV_DONE;
                end
            end
            DV_DONE:  state_next = DV_IDLE;
            default:  state_next = DV_IDLE;
        endcase
    end

    always_comb begin
        rsp.done = (state_reg == DV_DONE);
        rsp.quo  = q_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            DV_SCALE: begin
                rem_reg  <= scaled;
                q_reg    <= '0;
                step_reg <= DIV_TOP_STEP;
            end
            DV_ITER: begin
                if (step_reg == DIV_TOP_STEP) begin
                    // quotient of 256 or more: saturate
                    if (fits) q_reg <= PCT_MAX;
                end else begin
                    q_reg <= {q_reg[PCT_W-2:0], fits};
                    if (fits) rem_reg <= trial[NW-1:0];
                end
                if (step_reg != 4'd0) step_reg <= step_reg - 4'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> design/power_state_residency_percent.sv
// Top level of the idle-state residency percentage block.
//
// Usage: each item on the s_ stream is one sample: a millisecond timestamp
// and three cumulative idle-state residency counters. For every accepted
// item exactly one result item leaves on the m_ stream: a status code and
// four rounded percentages (deep, deeper, deepest, combined), each
// min(255, (100*delta + elapsed/2) / elapsed) against the previous sample.
// The first sample after reset only primes the stored sample (need_more);
// a sample with zero elapsed time is dropped (no_time) and the stored
// sample is kept. counters_present on the APB port masks counters to zero.
// The special cases pass the diff and finish states into the output register;
// a full result passes diff, sum, four divisions and finish. The divisions run
// one after another through one shared divider, each a start, a scale, one to
// nine compare-subtract steps and a done step; finish waits while the output
// register is full and not taken. s_tready is high only while the sequencer is
// idle, so one item is in work at a time.
// A finished result waits in the output register while the receiver
// stalls; the next item can still be taken and computed meanwhile.
// Reset clears the stored sample, the output valid and sets the mask to 7.
module power_state_residency_percent #(
    parameter int COUNTER_WIDTH = psrp_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [psrp_pkg::PADDR_W-1:0]     paddr,
    input  logic [psrp_pkg::PDATA_W-1:0]     pwdata,
    output logic [psrp_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    // Sample stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // timestamp_ms[47:0], deep_ms[95:48], deeper_ms[143:96], deepest_ms[191:144]
    input  logic [psrp_pkg::IN_DATA_W-1:0]   s_tdata,
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], deep_pct[9:2], deeper_pct[17:10], deepest_pct[25:18],
    // combined_pct[33:26], zero fill [39:34]
    output logic [psrp_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import psrp_pkg::*;

    localparam int CW = COUNTER_WIDTH;
    localparam int SW = CW + 2;

    // Take a fixed-width input field down (or up) to the counter width
    function automatic logic [CW-1:0] fit(input logic [FIELD_W-1:0] f);
        logic [63:0] w;
        w = 64'(f);
        return w[CW-1:0];
    endfunction

    top_state_t        state_reg, state_next;
    logic [MASK_W-1:0] mask_reg;
    logic              have_prev_reg;
    logic [CW-1:0]     prev_time_reg, prev_deep_reg, prev_deeper_reg, prev_deepest_reg;
    logic [CW-1:0]     cur_time_reg, cur_deep_reg, cur_deeper_reg, cur_deepest_reg;
    logic [CW-1:0]     dt_reg, da_reg, db_reg, dc_reg;
    logic [SW-1:0]     sum_reg;
    chan_t             chan_reg;
    logic [PCT_W-1:0]  pct_reg [4];
    status_t           status_reg;
    logic              m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [CW-1:0]     dt_comb;
    logic              out_free;
    logic              div_start;
    logic [SW-1:0]     div_num;
    div_rsp_t          div_rsp;
    logic              cfg_write;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_COUNTERS_PRESENT) ?
                       PDATA_W'(mask_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= MASK_RESET;
        end else if (cfg_write && paddr[2] == REG_COUNTERS_PRESENT) begin
            mask_reg <= pwdata[MASK_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    assign dt_comb  = cur_time_reg - prev_time_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_DIFF;
            ST_DIFF: begin
                // first sample or zero elapsed time: report at once
                if (!have_prev_reg || dt_comb == '0) state_next = ST_FINISH;
                else                                 state_next = ST_SUM;
            end
            ST_SUM:    state_next = ST_START;
            ST_START:  state_next = ST_WAIT;
            ST_WAIT: begin
                if (div_rsp.done) begin
                    if (chan_reg == CH_COMBINED) state_next = ST_FINISH;
                    else                         state_next = ST_START;
                end
            end
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_START);
        case (chan_reg)
            CH_DEEP:     div_num = SW'(da_reg);
            CH_DEEPER:   div_num = SW'(db_reg);
            CH_DEEPEST:  div_num = SW'(dc_reg);
            CH_COMBINED: div_num = sum_reg;
            default:     div_num = sum_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- stored sample ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg    <= 1'b0;
            prev_time_reg    <= '0;
            prev_deep_reg    <= '0;
            prev_deeper_reg  <= '0;
            prev_deepest_reg <= '0;
        end else if (state_reg == ST_DIFF && (!have_prev_reg || dt_comb != '0)) begin
            // keep the new sample unless a stored one exists and it carries no elapsed time
            have_prev_reg    <= 1'b1;
            prev_time_reg    <= cur_time_reg;
            prev_deep_reg    <= cur_deep_reg;
            prev_deeper_reg  <= cur_deeper_reg;
            prev_deepest_reg <= cur_deepest_reg;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // masked counters read as zero
                    cur_time_reg    <= fit(s_tdata[FIELD_W-1:0]);
                    cur_deep_reg    <= mask_reg[BIT_DEEP] ?
                                       fit(s_tdata[2*FIELD_W-1:FIELD_W]) : '0;
                    cur_deeper_reg  <= mask_reg[BIT_DEEPER] ?
                                       fit(s_tdata[3*FIELD_W-1:2*FIELD_W]) : '0;
                    cur_deepest_reg <= mask_reg[BIT_DEEPEST] ?
                                       fit(s_tdata[4*FIELD_W-1:3*FIELD_W]) : '0;
                end
            end
            ST_DIFF: begin
                dt_reg   <= dt_comb;
                da_reg   <= cur_deep_reg - prev_deep_reg;
                db_reg   <= cur_deeper_reg - prev_deeper_reg;
                dc_reg   <= cur_deepest_reg - prev_deepest_reg;
                chan_reg <= CH_DEEP;
                for (int i = 0; i < 4; i++) pct_reg[i] <= '0;
                if (!have_prev_reg)      status_reg <= STATUS_NEED_MORE;
                else if (dt_comb == '0)  status_reg <= STATUS_NO_TIME;
                else                     status_reg <= STATUS_VALID;
            end
            ST_SUM: begin
                sum_reg <= SW'(da_reg) + SW'(db_reg) + SW'(dc_reg);
            end
            ST_WAIT: begin
                if (div_rsp.done) begin
                    pct_reg[chan_reg] <= div_rsp.quo;
                    if (chan_reg != CH_COMBINED) chan_reg <= chan_t'(chan_reg + 2'd1);
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FINISH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_data_reg <= {6'b0, pct_reg[CH_COMBINED], pct_reg[CH_DEEPEST],
                           pct_reg[CH_DEEPER], pct_reg[CH_DEEP], status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- shared divider ----------------
    psrp_div #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (dt_reg),
        .rsp     (div_rsp)
    );

endmodule
